/* rtl/core/tbi_pkg.sv */
// tbi_pkg: shared types and constants for the trajectory blend interpolator
// register index codes, blend mode codes, field widths and reset values
// no dependencies
`timescale 1ns / 1ps

package tbi_pkg;

	// widths fixed by the register and field definitions
	localparam int CNT_W      = 13;
	localparam int CNT_MAX    = 8191;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [MODE_W-1:0] {
		BLEND_LINEAR  = 2'd0,
		BLEND_CUBIC   = 2'd1,
		BLEND_QUINTIC = 2'd2
	} blend_mode_t;

	typedef enum logic {
		REG_BLEND_MODE     = 1'b0,
		REG_INTERVAL_COUNT = 1'b1
	} cfg_reg_t;

	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [CNT_W-1:0]      count_t;

	localparam blend_mode_t MODE_RESET  = BLEND_QUINTIC;
	localparam count_t      COUNT_RESET = 13'd2;

endpackage

/* rtl/core/trajectory_blend_interpolator_top.sv */
// trajectory_blend_interpolator_top: one blended point of a joint segment per transaction
// depends on tbi_pkg for register codes, blend modes and widths
`timescale 1ns / 1ps

// pipeline: POSITION_WIDTH + 9 register stages from an input transaction to its result
// throughput: one transaction per cycle, set by the one-bit-per-stage divider,
// which is fully pipelined; a stalled output freezes the pipe, the head stage
// still takes one transaction while it is empty
// reset: arst_n clears all valid bits and loads blend_mode = quintic and
// interval_count = 2; config-derived denominators settle through n_q, ncu_q and den_q after a write
module trajectory_blend_interpolator_top #(
	parameter int MAX_INTERVALS  = 4096,
	parameter int POSITION_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_write,
	input  tbi_pkg::cfg_reg_t           cfg_index,
	input  tbi_pkg::cfg_data_t          cfg_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [POSITION_WIDTH-1:0] start_position,
	input  logic signed [POSITION_WIDTH-1:0] end_position,
	input  tbi_pkg::count_t             point_offset,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [POSITION_WIDTH-1:0] position,
	output logic                        offset_clamped
);
	import tbi_pkg::*;

	localparam int P      = POSITION_WIDTH;
	// largest usable interval count, also bounded by the 13-bit register
	localparam int N_MAX  = (MAX_INTERVALS < CNT_MAX) ? MAX_INTERVALS : CNT_MAX;
	localparam int NW     = $clog2(N_MAX + 1);
	localparam int N2W    = 2 * NW;
	localparam int N3W    = 3 * NW;
	localparam int DW     = 5 * NW;          // covers N^5 and any numerator
	localparam int C3W    = NW + 2;          // 3N - 2k
	localparam int FW     = 2 * NW + 4;      // 10N^2 - 15kN + 6k^2
	localparam int PROD_W = N3W + FW;
	localparam int CH     = (DW + 2) / 3;    // numerator chunk for partial products
	localparam int AW     = P + DW;          // dividend width
	localparam int NS     = P + 9;           // total pipeline stages
	localparam int S_RND  = P + 8;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	blend_mode_t blend_mode_q;
	count_t      interval_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q     <= MODE_RESET;
			interval_count_q <= COUNT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BLEND_MODE: begin
					blend_mode_q <= blend_mode_t'(cfg_data[MODE_W-1:0]);
				end
				REG_INTERVAL_COUNT: begin
					interval_count_q <= cfg_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// effective interval count: zero reads as one, large values saturate
	logic [NW-1:0] n_eff;

	always_comb begin
		if (interval_count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(interval_count_q) > N_MAX) begin
			n_eff = NW'(N_MAX);
		end else begin
			n_eff = NW'(interval_count_q);
		end
	end

	// ---------------------------------------------------------------
	// denominator, derived from config only; it runs freely and settles
	// long before the first transaction after a write reaches the divider
	// ---------------------------------------------------------------
	logic [NW-1:0]  n_q, n2_q;
	logic [N2W-1:0] nsq_q, nsq2_q;
	logic [N3W-1:0] ncu_q;
	logic [DW-1:0]  den_q;

	always_ff @(posedge clk) begin
		n_q    <= n_eff;
		nsq_q  <= N2W'(n_eff) * N2W'(n_eff);
		n2_q   <= n_q;
		nsq2_q <= nsq_q;
		ncu_q  <= N3W'(nsq_q) * N3W'(n_q);
		case (blend_mode_q)
			BLEND_LINEAR: den_q <= DW'(n2_q);
			BLEND_CUBIC:  den_q <= DW'(ncu_q);
			default:      den_q <= DW'(ncu_q) * DW'(nsq2_q);
		endcase
	end

	// ---------------------------------------------------------------
	// pipeline control: the whole pipe advances unless the output
	// register holds a stalled result; the head stage may fill a bubble
	// ---------------------------------------------------------------
	logic [NS:1] vld_s;
	logic        adv;
	logic        ld1;

	assign out_valid = vld_s[NS];
	assign adv       = !vld_s[NS] || !out_stall;
	assign ld1       = adv || !vld_s[1];
	assign in_stall  = vld_s[1] && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld1) begin
				vld_s[1] <= in_valid;
			end
			if (adv) begin
				vld_s[NS:2] <= vld_s[NS-1:1];
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: offset clamp and segment delta
	// ---------------------------------------------------------------
	logic          k_clamp;
	logic [NW-1:0] k_eff;

	assign k_clamp = point_offset > CNT_W'(n_eff);
	assign k_eff   = k_clamp ? n_eff : point_offset[NW-1:0];

	logic [P-1:0]  x0_s1;
	logic [P:0]    d_s1;
	logic [NW-1:0] k_s1;
	logic          clamp_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			x0_s1    <= start_position;
			d_s1     <= {end_position[P-1], end_position} - {start_position[P-1], start_position};
			k_s1     <= k_eff;
			clamp_s1 <= k_clamp;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: delta magnitude, k^2, kN, cubic factor
	// ---------------------------------------------------------------
	logic [P:0] d_neg;

	assign d_neg = (P+1)'(0) - d_s1;

	logic [P-1:0]   x0_s2, mag_s2;
	logic           neg_s2, clamp_s2;
	logic [NW-1:0]  k_s2;
	logic [N2W-1:0] kk_s2, kn_s2;
	logic [C3W-1:0] c3_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s2    <= x0_s1;
			neg_s2   <= d_s1[P];
			mag_s2   <= d_s1[P] ? d_neg[P-1:0] : d_s1[P-1:0];
			k_s2     <= k_s1;
			kk_s2    <= N2W'(k_s1) * N2W'(k_s1);
			kn_s2    <= N2W'(k_s1) * N2W'(n_eff);
			c3_s2    <= (C3W'(n_eff) << 1) + C3W'(n_eff) - (C3W'(k_s1) << 1);
			clamp_s2 <= clamp_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: pick the power of k and the polynomial factor
	// ---------------------------------------------------------------
	logic [N3W-1:0] kkk;
	logic [FW-1:0]  p5;
	logic [N3W-1:0] pw;
	logic [FW-1:0]  fa;

	assign kkk = N3W'(kk_s2) * N3W'(k_s2);
	// modular sum, the true value is positive for k <= N
	assign p5  = FW'(10) * FW'(nsq_q) + FW'(6) * FW'(kk_s2) - FW'(15) * FW'(kn_s2);

	always_comb begin
		case (blend_mode_q)
			BLEND_LINEAR: begin
				pw = N3W'(k_s2);
				fa = FW'(1);
			end
			BLEND_CUBIC: begin
				pw = N3W'(kk_s2);
				fa = FW'(c3_s2);
			end
			default: begin
				pw = kkk;
				fa = p5;
			end
		endcase
	end

	logic [P-1:0]   x0_s3, mag_s3;
	logic           neg_s3, clamp_s3;
	logic [N3W-1:0] pw_s3;
	logic [FW-1:0]  fa_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s3    <= x0_s2;
			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
			pw_s3    <= pw;
			fa_s3    <= fa;
			clamp_s3 <= clamp_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: blend numerator
	// ---------------------------------------------------------------
	logic [PROD_W-1:0] num_prod;

	assign num_prod = PROD_W'(pw_s3) * PROD_W'(fa_s3);

	logic [P-1:0]  x0_s4, mag_s4;
	logic          neg_s4, clamp_s4;
	logic [DW-1:0] num_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s4    <= x0_s3;
			neg_s4   <= neg_s3;
			mag_s4   <= mag_s3;
			num_s4   <= num_prod[DW-1:0];
			clamp_s4 <= clamp_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: magnitude times numerator, three partial products
	// ---------------------------------------------------------------
	logic [3*CH-1:0] num_x;

	assign num_x = (3*CH)'(num_s4);

	logic [P-1:0]    x0_s5;
	logic            neg_s5, clamp_s5;
	logic [P+CH-1:0] pp0_s5, pp1_s5, pp2_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s5    <= x0_s4;
			neg_s5   <= neg_s4;
			pp0_s5   <= (P+CH)'(mag_s4) * (P+CH)'(num_x[CH-1:0]);
			pp1_s5   <= (P+CH)'(mag_s4) * (P+CH)'(num_x[2*CH-1:CH]);
			pp2_s5   <= (P+CH)'(mag_s4) * (P+CH)'(num_x[3*CH-1:2*CH]);
			clamp_s5 <= clamp_s4;
		end
	end

	// ---------------------------------------------------------------
	// stages 6 and 7: accumulate the dividend
	// ---------------------------------------------------------------
	logic [P-1:0]    x0_s6;
	logic            neg_s6, clamp_s6;
	logic [AW-1:0]   acc_s6;
	logic [P+CH-1:0] pp2_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s6    <= x0_s5;
			neg_s6   <= neg_s5;
			acc_s6   <= AW'(pp0_s5) + (AW'(pp1_s5) << CH);
			pp2_s6   <= pp2_s5;
			clamp_s6 <= clamp_s5;
		end
	end

	// element 0 is stage 7, element j is divider stage 7 + j
	logic [AW-1:0] rem_sd   [0:P];
	logic [P-1:0]  q_sd     [0:P];
	logic [P-1:0]  x0_sd    [0:P];
	logic          neg_sd   [0:P];
	logic          clamp_sd [0:P];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sd[0]   <= acc_s6 + (AW'(pp2_s6) << (2*CH));
			q_sd[0]     <= '0;
			x0_sd[0]    <= x0_s6;
			neg_sd[0]   <= neg_s6;
			clamp_sd[0] <= clamp_s6;
		end
	end

	// ---------------------------------------------------------------
	// restoring divider, one quotient bit per stage, msb first;
	// the quotient never exceeds the delta magnitude, so P bits suffice
	// ---------------------------------------------------------------
	for (genvar j = 1; j <= P; j++) begin : g_div
		localparam int B = P - j;

		logic [AW-1:0] dsh;
		logic [AW:0]   diff;
		logic          take;

		assign dsh  = AW'(den_q) << B;
		assign diff = {1'b0, rem_sd[j-1]} - {1'b0, dsh};
		assign take = !diff[AW];

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[j]   <= take ? diff[AW-1:0] : rem_sd[j-1];
				// bit B is still clear, only higher bits are set so far
				q_sd[j]     <= q_sd[j-1] | ({{(P-1){1'b0}}, take} << B);
				x0_sd[j]    <= x0_sd[j-1];
				neg_sd[j]   <= neg_sd[j-1];
				clamp_sd[j] <= clamp_sd[j-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// rounding stage: round half up on the magnitude
	// ---------------------------------------------------------------
	logic [P-1:0] x0_sr, q_sr;
	logic         neg_sr, clamp_sr, rnd_sr;

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_sr    <= x0_sd[P];
			q_sr     <= q_sd[P];
			neg_sr   <= neg_sd[P];
			clamp_sr <= clamp_sd[P];
			rnd_sr   <= {rem_sd[P][DW-1:0], 1'b0} >= {1'b0, den_q};
		end
	end

	// ---------------------------------------------------------------
	// output stage: x0 + (q + rnd), or x0 - (q + rnd) as x0 + ~q + !rnd
	// ---------------------------------------------------------------
	logic [P-1:0] q_sel;
	logic         cin;

	assign q_sel = neg_sr ? ~q_sr : q_sr;
	assign cin   = neg_sr ? !rnd_sr : rnd_sr;

	logic [P-1:0] position_so;
	logic         clamp_so;

	always_ff @(posedge clk) begin
		if (adv) begin
			position_so <= x0_sr + q_sel + {{(P-1){1'b0}}, cin};
			clamp_so    <= clamp_sr;
		end
	end

	assign position       = position_so;
	assign offset_clamped = clamp_so;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// the divider leaves a remainder below the denominator
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_RND-1] |-> (rem_sd[P] < AW'(den_q)))
		else $error("divider remainder not below denominator");

	// a frozen pipe keeps every stage behind the head
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[NS:2]))
		else $error("pipeline valid bits moved while frozen");

	// an empty output register never back-pressures the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// an accepted transaction lands in the head stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[1])
		else $error("accepted transaction lost at head stage");

endmodule

/* verif/tb_trajectory_blend_interpolator_top.sv */
// testbench for trajectory_blend_interpolator_top: directed table, then randomized register
// settings with random payloads, each result checked against its typed row or the in-bench blend predictor
// depends on tbi_pkg and the trajectory_blend_interpolator_top rtl
`timescale 1ns / 1ps

module tb_trajectory_blend_interpolator_top;
	import tbi_pkg::*;

	localparam int POS_W         = 32;
	localparam int SPAN_MAX      = 4096;
	localparam int SETTLE_CYCLES = 4;      // lets the registered denominators settle after a write
	localparam int DRAIN_CYCLES  = 60;     // pipeline depth is 41 at this width
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASES        = 12;
	localparam int PHASE_POINTS  = 125;
	localparam int DIR_ROWS      = 24;

	localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
	localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0] POS_NEG1 = 32'hFFFF_FFFF;

	localparam cfg_data_t DATA_LINEAR  = cfg_data_t'(BLEND_LINEAR);
	localparam cfg_data_t DATA_CUBIC   = cfg_data_t'(BLEND_CUBIC);
	localparam cfg_data_t DATA_QUINTIC = cfg_data_t'(BLEND_QUINTIC);
	// unnamed mode three, written with every upper data bit set as well
	localparam cfg_data_t DATA_MODE3   = 13'h1FFF;

	// one expected point
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             clamp;
	} point_t;

	// one row of the directed table
	typedef struct packed {
		cfg_data_t        mode;
		cfg_data_t        count;
		logic [POS_W-1:0] x0;
		logic [POS_W-1:0] x1;
		count_t           k;
		bit               typed;
		logic [POS_W-1:0] pos;
		bit               clamp;
	} drow_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	cfg_reg_t                cfg_index;
	cfg_data_t               cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [POS_W-1:0] start_position;
	logic signed [POS_W-1:0] end_position;
	count_t                  point_offset;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [POS_W-1:0] position;
	logic                    offset_clamped;

	// predictor copy of the two registers
	logic [MODE_W-1:0] blend_sel;
	count_t            span_count;

	point_t pending_points[$];
	int     errors = 0;
	int     cycles = 0;
	int     points_sent;
	int     points_checked = 0;
	int     clamps_seen;
	int     settings_used;
	int     stall_left = 0;
	bit     quiet;

	drow_t dir_rows [DIR_ROWS] = '{
		// reset settings: quintic, two intervals; midpoint is exactly one half
		'{DATA_QUINTIC, 13'd2, 32'd0, 32'd2, 13'd1, 1'b1, 32'd1, 1'b0},
		'{DATA_QUINTIC, 13'd2, POS_MIN, POS_MAX, 13'd0, 1'b1, POS_MIN, 1'b0},
		'{DATA_QUINTIC, 13'd2, POS_MIN, POS_MAX, 13'd2, 1'b1, POS_MAX, 1'b0},
		// largest offset clamps to the end point
		'{DATA_QUINTIC, 13'd2, POS_MAX, POS_MIN, 13'd8191, 1'b1, POS_MIN, 1'b1},
		'{DATA_QUINTIC, 13'd2, 32'h1234_5678, 32'hFFFF_FFFB, 13'd3, 1'b1, 32'hFFFF_FFFB, 1'b1},
		// rounding ties go away from the start point, both directions
		'{DATA_LINEAR, 13'd2, 32'd0, 32'd1, 13'd1, 1'b1, 32'd1, 1'b0},
		'{DATA_LINEAR, 13'd2, 32'd0, POS_NEG1, 13'd1, 1'b1, POS_NEG1, 1'b0},
		'{DATA_LINEAR, 13'd2, POS_MIN, POS_MAX, 13'd1, 1'b0, 32'd0, 1'b0},
		'{DATA_CUBIC, 13'd4096, 32'd0, POS_MAX, 13'd1, 1'b0, 32'd0, 1'b0},
		'{DATA_CUBIC, 13'd4096, POS_MIN, POS_MAX, 13'd4095, 1'b0, 32'd0, 1'b0},
		'{DATA_CUBIC, 13'd4096, POS_MIN, POS_MAX, 13'd4096, 1'b1, POS_MAX, 1'b0},
		'{DATA_CUBIC, 13'd4096, POS_MAX, POS_MIN, 13'd4097, 1'b1, POS_MIN, 1'b1},
		// mode three acts as quintic, count above the maximum saturates
		'{DATA_MODE3, 13'd8191, 32'd0, POS_MIN, 13'd2048, 1'b0, 32'd0, 1'b0},
		'{DATA_MODE3, 13'd8191, 32'h0001_0000, 32'hFFFF_0000, 13'd4096, 1'b1,
			32'hFFFF_0000, 1'b0},
		'{DATA_MODE3, 13'd8191, 32'd0, 32'd1, 13'd5000, 1'b1, 32'd1, 1'b1},
		// zero count behaves as one interval
		'{DATA_LINEAR, 13'd0, 32'd7, 32'd9, 13'd0, 1'b1, 32'd7, 1'b0},
		'{DATA_LINEAR, 13'd0, 32'd7, 32'd9, 13'd1, 1'b1, 32'd9, 1'b0},
		'{DATA_LINEAR, 13'd0, 32'd7, 32'd9, 13'd8191, 1'b1, 32'd9, 1'b1},
		'{DATA_CUBIC, 13'd1, 32'd100, 32'hFFFF_FF9C, 13'd1, 1'b1, 32'hFFFF_FF9C, 1'b0},
		'{DATA_QUINTIC, 13'd3, 32'hFFFF_FFF9, 32'd100, 13'd1, 1'b0, 32'd0, 1'b0},
		'{DATA_QUINTIC, 13'd4096, 32'd5, 32'd5, 13'd1234, 1'b1, 32'd5, 1'b0},
		'{DATA_LINEAR, 13'd4096, 32'd0, 32'd4096, 13'd1, 1'b0, 32'd0, 1'b0},
		'{DATA_CUBIC, 13'd2, 32'd0, 32'd1, 13'd1, 1'b0, 32'd0, 1'b0},
		'{DATA_QUINTIC, 13'd2, 32'd0, POS_NEG1, 13'd1, 1'b0, 32'd0, 1'b0}
	};

	trajectory_blend_interpolator_top #(
		.MAX_INTERVALS  (SPAN_MAX),
		.POSITION_WIDTH (POS_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_position (start_position),
		.end_position   (end_position),
		.point_offset   (point_offset),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position       (position),
		.offset_clamped (offset_clamped)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// interval count as the block uses it: zero reads as one, large values saturate
	function automatic int effective_span();
		if (span_count == 0)
			return 1;
		if (span_count > SPAN_MAX)
			return SPAN_MAX;
		return int'(span_count);
	endfunction

	// position at tau = k/N under the current blend, offset rounded once, ties away from x0
	function automatic point_t blend_point(input logic [POS_W-1:0] x0, input logic [POS_W-1:0] x1,
			input count_t k_in);
		longint unsigned n;
		longint unsigned k;
		longint unsigned num;
		longint unsigned den;
		longint          a;
		longint          b;
		longint          d;
		logic [127:0]    prod;
		logic [127:0]    quo;
		logic [127:0]    rem;
		longint          res;
		point_t          p;
		n = longint'(effective_span());
		k = k_in;
		p.clamp = 1'b0;
		if (k > n) begin
			k = n;
			p.clamp = 1'b1;
		end
		case (blend_sel)
			BLEND_LINEAR: begin
				num = k;
				den = n;
			end
			BLEND_CUBIC: begin
				num = k * k * (3 * n - 2 * k);
				den = n * n * n;
			end
			default: begin
				// quintic polynomial stays positive for every k in 0..n
				num = k * k * k * (10 * n * n + 6 * k * k - 15 * k * n);
				den = n * n * n * n * n;
			end
		endcase
		a = longint'($signed(x0));
		b = longint'($signed(x1));
		d = b - a;
		prod = 128'(d < 0 ? -d : d) * 128'(num);
		quo = prod / 128'(den);
		rem = prod % 128'(den);
		if (2 * rem >= 128'(den))
			quo = quo + 1;
		res = (d < 0) ? a - longint'(quo) : a + longint'(quo);
		p.pos = res[POS_W-1:0];
		return p;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [POS_W-1:0] rand_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: return POS_MIN;
				1: return POS_MAX;
				2: return '0;
				default: return POS_NEG1;
			endcase
		end
		// positions within 2^20 either side of zero
		if (r < 30)
			return POS_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		return POS_W'($urandom);
	endfunction

	function automatic count_t rand_offset();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = effective_span();
		if (r < 75)
			return count_t'($urandom_range(0, n));
		if (r < 85)
			return (r[0]) ? count_t'(n) : '0;
		if (r < 95)
			return count_t'($urandom_range(n, CNT_MAX));
		return count_t'($urandom_range(0, CNT_MAX));
	endfunction

	task automatic flag_mismatch(input string what, input logic [POS_W-1:0] got,
			input logic [POS_W-1:0] want);
		$display("mismatch: %s at result %0d, got %h expected %h", what, points_checked, got, want);
		errors++;
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// writes both registers while the pipe is empty, then lets the denominators settle
	task automatic load_settings(input cfg_data_t mode_data, input cfg_data_t count_data);
		in_valid <= 1'b0;
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= REG_BLEND_MODE;
		cfg_data  <= mode_data;
		@(posedge clk);
		cfg_index <= REG_INTERVAL_COUNT;
		cfg_data  <= count_data;
		@(posedge clk);
		cfg_write  <= 1'b0;
		blend_sel  = mode_data[MODE_W-1:0];
		span_count = count_data;
		settings_used++;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one input transaction; valid stays high afterwards for a back-to-back follower
	task automatic send_point(input logic [POS_W-1:0] x0, input logic [POS_W-1:0] x1,
			input count_t k, input bit typed, input point_t typed_point);
		int     g;
		point_t p;
		g = quiet ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid       <= 1'b1;
		start_position <= x0;
		end_position   <= x1;
		point_offset   <= k;
		do
			@(posedge clk);
		while (in_stall);
		p = typed ? typed_point : blend_point(x0, x1, k);
		pending_points.push_back(p);
		points_sent++;
		if (p.clamp)
			clamps_seen++;
	endtask

	// receiver back-pressure, independent of whether a result is waiting
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = gap_len();
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each accepted result transaction with the oldest expectation
	always @(posedge clk) begin
		point_t p;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				flag_mismatch("result with nothing pending", position, '0);
			end else begin
				p = pending_points.pop_front();
				if (position !== p.pos)
					flag_mismatch("position", position, p.pos);
				if (offset_clamped !== p.clamp)
					flag_mismatch("offset_clamped", POS_W'(offset_clamped), POS_W'(p.clamp));
				points_checked++;
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				pending_points.size());
			$display("** trajectory_blend_interpolator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		drow_t     row;
		point_t    tp;
		cfg_data_t mode_raw;
		cfg_data_t count_raw;
		cfg_data_t mode_data;
		cfg_data_t count_data;
		points_sent    = 0;
		clamps_seen    = 0;
		settings_used  = 1;
		quiet          = 1'b0;
		blend_sel      = MODE_RESET;
		span_count     = COUNT_RESET;
		mode_raw       = cfg_data_t'(MODE_RESET);
		count_raw      = COUNT_RESET;
		arst_n         <= 1'b0;
		cfg_write      <= 1'b0;
		cfg_index      <= REG_BLEND_MODE;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		start_position <= '0;
		end_position   <= '0;
		point_offset   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: reload registers only where a row asks for new settings
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_rows[i];
			if (row.mode != mode_raw || row.count != count_raw) begin
				load_settings(row.mode, row.count);
				mode_raw  = row.mode;
				count_raw = row.count;
			end
			tp.pos   = row.pos;
			tp.clamp = row.clamp;
			send_point(row.x0, row.x1, row.k, row.typed, tp);
		end

		// random phases: every mode in turn, counts from the extremes and the range
		for (int ph = 0; ph < PHASES; ph++) begin
			mode_data = (cfg_data_t'($urandom) & 13'h1FFC) | cfg_data_t'(ph % 4);
			case (ph)
				0: count_data = 13'd1;
				1: count_data = 13'd4096;
				2: count_data = 13'd8191;
				default: begin
					case ($urandom_range(0, 3))
						0: count_data = cfg_data_t'($urandom_range(0, CNT_MAX));
						1: count_data = cfg_data_t'($urandom_range(1, 8));
						default: count_data = cfg_data_t'($urandom_range(1, SPAN_MAX));
					endcase
				end
			endcase
			load_settings(mode_data, count_data);
			// some phases run with no idling on either side
			quiet = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < PHASE_POINTS; j++)
				send_point(rand_position(), rand_position(), rand_offset(), 1'b0, tp);
			quiet = 1'b0;
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d point transactions (%0d from the table) under %0d register settings",
			points_sent, DIR_ROWS, settings_used);
		$display("checked %0d results, %0d of them clamped, %0d mismatches",
			points_checked, clamps_seen, errors);
		if (errors == 0 && pending_points.size() == 0) begin
			$display("** trajectory_blend_interpolator_top: PASSED **");
		end else begin
			$display("** trajectory_blend_interpolator_top: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/tbi_pkg.sv
rtl/core/trajectory_blend_interpolator_top.sv
verif/tb_trajectory_blend_interpolator_top.sv
